// ===== hdl/tvc_pkg.sv =====
// Shared types and constants for the TEA-variant block cipher with chaining modes.
`timescale 1ns / 1ps

package tvc_pkg;

    typedef logic [7:0][31:0] t_key;

    localparam logic [2:0] MODE_ECB  = 3'd0;
    localparam logic [2:0] MODE_CBC  = 3'd1;
    localparam logic [2:0] MODE_CFB  = 3'd2;
    localparam logic [2:0] MODE_OFB  = 3'd3;
    localparam logic [2:0] MODE_CTR  = 3'd4;
    localparam logic [2:0] MODE_PCBC = 3'd5;

    localparam logic [2:0] REG_KEY_01 = 3'd0;
    localparam logic [2:0] REG_KEY_23 = 3'd1;
    localparam logic [2:0] REG_KEY_45 = 3'd2;
    localparam logic [2:0] REG_KEY_67 = 3'd3;
    localparam logic [2:0] REG_IV     = 3'd4;
    localparam logic [2:0] REG_MODE   = 3'd5;
    localparam logic [2:0] REG_DEC    = 3'd6;
    localparam logic [2:0] REG_WIDE   = 3'd7;

    localparam logic [3:0] FULL_BYTES = 4'd8;
    localparam logic [7:0] PAD_BYTE   = 8'h01;

endpackage

// ===== hdl/tvc_round.sv =====
// Shared half-round unit: adds or subtracts the keyed mix of one word to the other.
`timescale 1ns / 1ps

module tvc_round #(
    parameter int IW = 7
) (
    input  logic [31:0]       i_src,
    input  logic [31:0]       i_dst,
    input  tvc_pkg::t_key     i_key,
    input  logic [IW-1:0]     i_idx,
    input  logic              i_wide,
    input  logic              i_dec,
    output logic [31:0]       o_dst
);
    import tvc_pkg::*;

    logic [2:0]  kidx;
    logic [2:0]  ksel;
    logic [31:0] mix;

    assign kidx  = 3'(i_idx);
    assign ksel  = i_wide ? kidx : {1'b0, kidx[1:0]};
    assign mix   = i_src + ((i_src << 6) ^ (i_src >> 8)) + i_key[ksel] + 32'(i_idx);
    assign o_dst = i_dec ? (i_dst - mix) : (i_dst + mix);

endmodule

// ===== hdl/tea_variant_cipher_with_modes_top.sv =====
// Top level: configuration registers, sequencer, chaining logic and output register.
`timescale 1ns / 1ps
// An accepted block runs N half-round steps, where N is ROUNDS_SHORT_KEY or ROUNDS_LONG_KEY,
// then its result is written to the output register once the slot is free; a rejected
// short block skips the steps. The single shared half-round unit takes one item at a time.
// The next item is accepted while a finished result still waits in the output register.
// Synchronous active-low reset clears the registers, the chaining value and the sequencer.

module tea_variant_cipher_with_modes_top #(
    parameter int ROUNDS_SHORT_KEY = 48,
    parameter int ROUNDS_LONG_KEY  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_data_block,
    input  logic [3:0]  i_byte_count,
    input  logic        i_first_block,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_out_block,
    output logic [2:0]  o_pad_count,
    output logic        o_status,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import tvc_pkg::*;

    localparam int MAX_R = (ROUNDS_SHORT_KEY > ROUNDS_LONG_KEY) ?
                           ROUNDS_SHORT_KEY : ROUNDS_LONG_KEY;
    localparam int IW = (MAX_R > 2) ? $clog2(MAX_R) : 1;
    localparam logic [IW-1:0] LAST_SHORT = IW'(ROUNDS_SHORT_KEY - 1);
    localparam logic [IW-1:0] LAST_LONG  = IW'(ROUNDS_LONG_KEY - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    t_key        r_key;
    logic [63:0] r_iv;
    logic [2:0]  r_mode;
    logic        r_dec;
    logic        r_wide;

    logic [1:0]    r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [31:0]   r_l, n_l, r_r, n_r;
    logic [63:0]   r_p, n_p;
    logic [63:0]   r_chain, n_chain;
    logic [2:0]    r_pad, n_pad;
    logic          r_rej, n_rej;
    logic          r_dec_run, n_dec_run;
    logic          r_out_valid, n_out_valid;
    logic [63:0]   r_out_block, n_out_block;
    logic [2:0]    r_out_pad, n_out_pad;
    logic          r_out_status, n_out_status;

    logic          accept;
    logic          short_blk;
    logic [3:0]    cnt;
    logic [63:0]   padded;
    logic [2:0]    pad_val;
    logic [63:0]   c_load;
    logic [63:0]   cin;
    logic          cdec;
    logic [IW-1:0] last_idx;
    logic [IW-1:0] end_idx;
    logic [31:0]   rnd_src, rnd_dst, rnd_out;
    logic [63:0]   kout;
    logic [63:0]   fin_out;
    logic [63:0]   fin_chain;
    logic          slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_block = r_out_block;
    assign o_pad_count = r_out_pad;
    assign o_status    = r_out_status;

    assign last_idx  = r_wide ? LAST_LONG : LAST_SHORT;
    assign end_idx   = r_dec_run ? '0 : last_idx;
    assign short_blk = (i_byte_count < FULL_BYTES);
    assign cnt       = short_blk ? i_byte_count : FULL_BYTES;
    assign c_load    = i_first_block ? r_iv : r_chain;
    assign slot_free = !r_out_valid || i_out_ready;
    assign kout      = {r_r, r_l};

    always_comb begin
        padded = i_data_block;
        for (int b = 0; b < 8; b++) begin
            if (!r_dec && (4'(b) >= cnt)) begin
                padded[8*b +: 8] = PAD_BYTE;
            end
        end
        if (r_dec || !short_blk) begin
            pad_val = '0;
        end else if (cnt == '0) begin
            pad_val = 3'd7;
        end else begin
            pad_val = 3'(FULL_BYTES - cnt);
        end
    end

    always_comb begin
        cin  = padded;
        cdec = r_dec;
        case (r_mode)
            MODE_CBC, MODE_PCBC: begin
                cin = r_dec ? padded : (padded ^ c_load);
            end
            MODE_CFB, MODE_OFB, MODE_CTR: begin
                cin  = c_load;
                cdec = 1'b0;
            end
            default: begin
                cin = padded;
            end
        endcase
    end

    assign rnd_src = r_idx[0] ? r_r : r_l;
    assign rnd_dst = r_idx[0] ? r_l : r_r;

    tvc_round #(
        .IW(IW)
    ) u_round (
        .i_src  (rnd_src),
        .i_dst  (rnd_dst),
        .i_key  (r_key),
        .i_idx  (r_idx),
        .i_wide (r_wide),
        .i_dec  (r_dec_run),
        .o_dst  (rnd_out)
    );

    always_comb begin
        fin_out   = kout;
        fin_chain = r_chain;
        case (r_mode)
            MODE_ECB: begin
                fin_out = kout;
            end
            MODE_CBC: begin
                fin_out   = r_dec ? (kout ^ r_chain) : kout;
                fin_chain = r_dec ? r_p : kout;
            end
            MODE_CFB: begin
                fin_out   = kout ^ r_p;
                fin_chain = r_dec ? r_p : (kout ^ r_p);
            end
            MODE_OFB: begin
                fin_out   = kout ^ r_p;
                fin_chain = kout;
            end
            MODE_CTR: begin
                fin_out   = kout ^ r_p;
                fin_chain = r_chain + 64'd1;
            end
            MODE_PCBC: begin
                fin_out   = r_dec ? (kout ^ r_chain) : kout;
                fin_chain = r_p ^ fin_out;
            end
            default: begin
                fin_out = kout;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_l          = r_l;
        n_r          = r_r;
        n_p          = r_p;
        n_chain      = r_chain;
        n_pad        = r_pad;
        n_rej        = r_rej;
        n_dec_run    = r_dec_run;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_block  = r_out_block;
        n_out_pad    = r_out_pad;
        n_out_status = r_out_status;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_dec && short_blk) begin
                        n_rej   = 1'b1;
                        n_state = S_FIN;
                    end else begin
                        n_rej     = 1'b0;
                        n_l       = cin[31:0];
                        n_r       = cin[63:32];
                        n_p       = padded;
                        n_chain   = c_load;
                        n_pad     = pad_val;
                        n_dec_run = cdec;
                        n_idx     = cdec ? last_idx : '0;
                        n_state   = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (r_idx[0]) begin
                    n_l = rnd_out;
                end else begin
                    n_r = rnd_out;
                end
                if (r_idx == end_idx) begin
                    n_state = S_FIN;
                end else begin
                    n_idx = r_dec_run ? (r_idx - 1'b1) : (r_idx + 1'b1);
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    if (r_rej) begin
                        n_out_block  = '0;
                        n_out_pad    = '0;
                        n_out_status = 1'b1;
                    end else begin
                        n_out_block  = fin_out;
                        n_out_pad    = r_pad;
                        n_out_status = 1'b0;
                        n_chain      = fin_chain;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= '0;
            r_iv        <= '0;
            r_mode      <= MODE_ECB;
            r_dec       <= 1'b0;
            r_wide      <= 1'b0;
            r_state     <= S_IDLE;
            r_chain     <= '0;
            r_out_valid <= 1'b0;
            r_rej       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_KEY_01: r_key[1:0] <= i_cfg_data;
                    REG_KEY_23: r_key[3:2] <= i_cfg_data;
                    REG_KEY_45: r_key[5:4] <= i_cfg_data;
                    REG_KEY_67: r_key[7:6] <= i_cfg_data;
                    REG_IV:     r_iv       <= i_cfg_data;
                    REG_MODE:   r_mode     <= i_cfg_data[2:0];
                    REG_DEC:    r_dec      <= i_cfg_data[0];
                    REG_WIDE:   r_wide     <= i_cfg_data[0];
                    default:    r_wide     <= r_wide;
                endcase
            end
            r_state     <= n_state;
            r_chain     <= n_chain;
            r_out_valid <= n_out_valid;
            r_rej       <= n_rej;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_l          <= n_l;
        r_r          <= n_r;
        r_p          <= n_p;
        r_pad        <= n_pad;
        r_dec_run    <= n_dec_run;
        r_out_block  <= n_out_block;
        r_out_pad    <= n_out_pad;
        r_out_status <= n_out_status;
    end

    a_reject_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_out_block == '0 && o_pad_count == '0))
        else $error("Rejected item carries a nonzero payload.");

    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("Input accepted again while the previous item is in work.");

    a_idx_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_idx <= last_idx))
        else $error("Half-round index beyond the round count.");

    a_result_after_fin : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && slot_free) |=> (o_out_valid && o_in_ready))
        else $error("Finished item did not reach the output register.");

endmodule
